// File: rtl/core/sbpo_pkg.sv
// Shared constants for the sphere box push-out pipeline.
package sbpo_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int RADIUS_W        = 24;
    localparam int D_W             = RADIUS_W + 1;
    localparam int SQ_W            = 2 * D_W;
    localparam int LEN_W           = SQ_W / 2;
    localparam int QUO_W           = RADIUS_W;
    localparam int LANES           = 3;

endpackage

// File: rtl/core/sbpo_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
module sbpo_sqrt #(
    parameter int IN_W   = sbpo_pkg::SQ_W,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int RW = IN_W / 2;

    logic [IN_W-1:0]   rem_reg   [1:RW];
    logic [RW-1:0]     root_reg  [1:RW];
    logic              valid_reg [1:RW];
    logic [SIDE_W-1:0] side_reg  [1:RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int K = RW - 1 - j;
        logic [IN_W-1:0]   rem_cur;
        logic [RW-1:0]     root_cur;
        logic              valid_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [IN_W:0]     trial;
        logic [IN_W-1:0]   rem_next;
        logic [RW-1:0]     root_next;

        if (j == 0) begin : g_first
            assign rem_cur   = in_rad;
            assign root_cur  = '0;
            assign valid_cur = in_valid;
            assign side_cur  = in_side;
        end else begin : g_rest
            assign rem_cur   = rem_reg[j];
            assign root_cur  = root_reg[j];
            assign valid_cur = valid_reg[j];
            assign side_cur  = side_reg[j];
        end

        assign trial = ({1'b0, {(IN_W-RW){1'b0}}, root_cur} << (K + 1))
                     | ((IN_W+1)'(1) << (2 * K));

        always_comb begin
            rem_next  = rem_cur;
            root_next = root_cur;
            if ({1'b0, rem_cur} >= trial) begin
                rem_next  = rem_cur - trial[IN_W-1:0];
                root_next = root_cur | (RW'(1) << K);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                valid_reg[j+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
                side_reg[j+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

// File: rtl/core/sbpo_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module sbpo_div #(
    parameter int DEN_W  = sbpo_pkg::LEN_W,
    parameter int QUO_W  = sbpo_pkg::QUO_W,
    parameter int SIDE_W = 1
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [sbpo_pkg::LANES-1:0][DEN_W+QUO_W-1:0]   in_num,
    input  logic [DEN_W-1:0]                              in_den,
    input  logic [SIDE_W-1:0]                             in_side,
    output logic                                          out_valid,
    output logic [sbpo_pkg::LANES-1:0][QUO_W-1:0]         out_quo,
    output logic [SIDE_W-1:0]                             out_side
);

    import sbpo_pkg::*;

    localparam int NW = DEN_W + QUO_W;

    logic [LANES-1:0][NW-1:0]    num_reg   [1:QUO_W];
    logic [LANES-1:0][QUO_W-1:0] quo_reg   [1:QUO_W];
    logic [DEN_W-1:0]            den_reg   [1:QUO_W];
    logic                        valid_reg [1:QUO_W];
    logic [SIDE_W-1:0]           side_reg  [1:QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic [LANES-1:0][NW-1:0]    num_cur;
        logic [LANES-1:0][QUO_W-1:0] quo_cur;
        logic [DEN_W-1:0]            den_cur;
        logic                        valid_cur;
        logic [SIDE_W-1:0]           side_cur;
        logic [NW-1:0]               dsh;
        logic [LANES-1:0][NW-1:0]    num_next;
        logic [LANES-1:0][QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign num_cur   = in_num;
            assign quo_cur   = '0;
            assign den_cur   = in_den;
            assign valid_cur = in_valid;
            assign side_cur  = in_side;
        end else begin : g_rest
            assign num_cur   = num_reg[j];
            assign quo_cur   = quo_reg[j];
            assign den_cur   = den_reg[j];
            assign valid_cur = valid_reg[j];
            assign side_cur  = side_reg[j];
        end

        assign dsh = {{QUO_W{1'b0}}, den_cur} << K;

        always_comb begin
            num_next = num_cur;
            quo_next = quo_cur;
            for (int i = 0; i < LANES; i++) begin
                if (num_cur[i] >= dsh) begin
                    num_next[i] = num_cur[i] - dsh;
                    quo_next[i] = quo_cur[i] | (QUO_W'(1) << K);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j+1] <= 1'b0;
            end else if (en) begin
                valid_reg[j+1] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[j+1]  <= num_next;
                quo_reg[j+1]  <= quo_next;
                den_reg[j+1]  <= den_cur;
                side_reg[j+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

// File: rtl/core/sphere_box_push_out_top.sv
// Sphere versus axis-aligned box push-out pipeline, top level.
// Takes one beat per cycle and returns one beat per input beat, in order, through three
// front stages (clamp, squares, sum), 25 square root stages (one root bit each), two stages
// for overlap and scaling product, 24 divider stages (one quotient bit each) and the output
// register. m_tready low while a result beat waits freezes the whole pipeline.
module sphere_box_push_out_top #(
    parameter int COORD_WIDTH = sbpo_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sbpo_pkg::FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // pos_x, pos_y, pos_z, radius
    input  logic [((9*COORD_WIDTH+sbpo_pkg::RADIUS_W+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // new_x, new_y, new_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // pushed
    output logic m_tuser
);

    import sbpo_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int M_W       = ((3*CW+7)/8)*8;
    localparam int EXT_W     = (CW + 1 > D_W + 1) ? CW + 1 : D_W + 1;
    localparam int SW        = EXT_W + 1;
    localparam int OVL_W     = RADIUS_W + 2;
    localparam int NW        = LEN_W + QUO_W;
    localparam int EPS_RAW   = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int EPS_LEN   = (EPS_RAW > 0) ? EPS_RAW : 1;
    localparam logic signed [EXT_W-1:0] LIM_P  = EXT_W'((1 << RADIUS_W) - 1);
    localparam logic signed [EXT_W-1:0] LIM_N  = -LIM_P;
    localparam logic signed [SW-1:0]    SAT_HI = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0]    SAT_LO = -SAT_HI - SW'(1);

    typedef struct packed {
        logic [LANES-1:0][CW-1:0]  pos;
        logic [LANES-1:0][D_W-1:0] d;
        logic [RADIUS_W-1:0]       radius;
        logic                      far;
    } sq_side_t;

    typedef struct packed {
        logic [LANES-1:0][CW-1:0] pos;
        logic [LANES-1:0]         dsign;
        logic [RADIUS_W-1:0]      ovl;
        logic                     zero;
        logic                     push;
    } dv_side_t;

    logic adv;

    // stage 1: clamp and offset
    logic [LANES-1:0][CW-1:0]    in_bmin, in_bmax, in_pos;
    logic [RADIUS_W-1:0]         in_radius;
    logic [LANES-1:0][EXT_W-1:0] t1_d_next;
    logic                        t1_valid_reg;
    logic [LANES-1:0][EXT_W-1:0] t1_d_reg;
    logic [LANES-1:0][CW-1:0]    t1_pos_reg;
    logic [RADIUS_W-1:0]         t1_radius_reg;

    // stage 2: squares
    logic [LANES-1:0][SQ_W-1:0]  t2_sq_next;
    logic                        t2_far_next;
    logic                        t2_valid_reg;
    logic [LANES-1:0][SQ_W-1:0]  t2_sq_reg;
    logic [LANES-1:0][D_W-1:0]   t2_d_reg;
    logic [LANES-1:0][CW-1:0]    t2_pos_reg;
    logic [RADIUS_W-1:0]         t2_radius_reg;
    logic                        t2_far_reg;

    // stage 3: sum of squares
    logic                        t3_valid_reg;
    logic [SQ_W-1:0]             t3_sum_reg;
    sq_side_t                    t3_side_reg;

    logic                        sq_valid;
    logic [LEN_W-1:0]            sq_len;
    sq_side_t                    sq_side;

    // stage 4: overlap
    logic signed [OVL_W-1:0]     t4_ovl_next;
    logic [LANES-1:0][RADIUS_W-1:0] t4_dmag_next;
    logic                        t4_valid_reg;
    logic [LANES-1:0][RADIUS_W-1:0] t4_dmag_reg;
    logic [LANES-1:0]            t4_dsign_reg;
    logic [RADIUS_W-1:0]         t4_ovl_reg;
    logic                        t4_zero_reg;
    logic                        t4_push_reg;
    logic [LEN_W-1:0]            t4_len_reg;
    logic [LANES-1:0][CW-1:0]    t4_pos_reg;

    // stage 5: scaled offsets
    logic                        t5_valid_reg;
    logic [LANES-1:0][2*RADIUS_W-1:0] t5_prod_reg;
    logic [LEN_W-1:0]            t5_len_reg;
    dv_side_t                    t5_side_reg;
    logic [LANES-1:0][NW-1:0]    dv_num;

    logic                        dv_valid;
    logic [LANES-1:0][QUO_W-1:0] dv_quo;
    dv_side_t                    dv_side;

    // output
    logic [LANES-1:0][CW-1:0]    out_new_next;
    logic                        m_tvalid_reg;
    logic [LANES-1:0][CW-1:0]    m_new_reg;
    logic                        m_pushed_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            in_bmin[i] = s_tdata[i*CW +: CW];
            in_bmax[i] = s_tdata[(i+3)*CW +: CW];
            in_pos[i]  = s_tdata[(i+6)*CW +: CW];
        end
        in_radius = s_tdata[9*CW +: RADIUS_W];
    end

    always_comb begin
        logic signed [CW-1:0] c;
        for (int i = 0; i < LANES; i++) begin
            c = ($signed(in_pos[i]) < $signed(in_bmin[i])) ? in_bmin[i] : in_pos[i];
            c = ($signed(c) > $signed(in_bmax[i])) ? in_bmax[i] : c;
            t1_d_next[i] = EXT_W'($signed(in_pos[i])) - EXT_W'(c);
        end
    end

    always_comb begin
        logic signed [2*D_W-1:0] p;
        t2_far_next = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if ($signed(t1_d_reg[i]) > LIM_P || $signed(t1_d_reg[i]) < LIM_N) begin
                t2_far_next = 1'b1;
            end
            p = $signed(t1_d_reg[i][D_W-1:0]) * $signed(t1_d_reg[i][D_W-1:0]);
            t2_sq_next[i] = p[SQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            t1_valid_reg <= s_tvalid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= sq_valid;
            t5_valid_reg <= t4_valid_reg;
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_d_reg      <= t1_d_next;
            t1_pos_reg    <= in_pos;
            t1_radius_reg <= in_radius;
            t2_sq_reg     <= t2_sq_next;
            t2_far_reg    <= t2_far_next;
            t2_pos_reg    <= t1_pos_reg;
            t2_radius_reg <= t1_radius_reg;
            for (int i = 0; i < LANES; i++) begin
                t2_d_reg[i] <= t1_d_reg[i][D_W-1:0];
            end
            t3_sum_reg         <= t2_sq_reg[0] + t2_sq_reg[1] + t2_sq_reg[2];
            t3_side_reg.pos    <= t2_pos_reg;
            t3_side_reg.d      <= t2_d_reg;
            t3_side_reg.radius <= t2_radius_reg;
            t3_side_reg.far    <= t2_far_reg;
        end
    end

    sbpo_sqrt #(
        .IN_W   (SQ_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (t3_valid_reg),
        .in_rad    (t3_sum_reg),
        .in_side   (t3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_len),
        .out_side  (sq_side)
    );

    always_comb begin
        logic [D_W-1:0] neg;
        if (sq_len == '0) begin
            t4_ovl_next = $signed({2'b00, sq_side.radius}) - OVL_W'(EPS_LEN);
        end else begin
            t4_ovl_next = $signed({2'b00, sq_side.radius}) - $signed({1'b0, sq_len});
        end
        for (int i = 0; i < LANES; i++) begin
            neg = -sq_side.d[i];
            t4_dmag_next[i] = sq_side.d[i][D_W-1] ? neg[RADIUS_W-1:0]
                                                  : sq_side.d[i][RADIUS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t4_dmag_reg <= t4_dmag_next;
            for (int i = 0; i < LANES; i++) begin
                t4_dsign_reg[i] <= sq_side.d[i][D_W-1];
            end
            t4_ovl_reg  <= t4_ovl_next[RADIUS_W-1:0];
            t4_zero_reg <= (sq_len == '0);
            t4_push_reg <= !sq_side.far && !t4_ovl_next[OVL_W-1] && (t4_ovl_next != '0);
            t4_len_reg  <= sq_len;
            t4_pos_reg  <= sq_side.pos;

            for (int i = 0; i < LANES; i++) begin
                t5_prod_reg[i] <= t4_dmag_reg[i] * t4_ovl_reg;
            end
            t5_len_reg        <= t4_len_reg;
            t5_side_reg.pos   <= t4_pos_reg;
            t5_side_reg.dsign <= t4_dsign_reg;
            t5_side_reg.ovl   <= t4_ovl_reg;
            t5_side_reg.zero  <= t4_zero_reg;
            t5_side_reg.push  <= t4_push_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            dv_num[i] = NW'(t5_prod_reg[i]) + NW'(t5_len_reg >> 1);
        end
    end

    sbpo_div #(
        .DEN_W  (LEN_W),
        .QUO_W  (QUO_W),
        .SIDE_W ($bits(dv_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (t5_valid_reg),
        .in_num    (dv_num),
        .in_den    (t5_len_reg),
        .in_side   (t5_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    always_comb begin
        logic [QUO_W-1:0]     mag;
        logic signed [SW-1:0] corr;
        logic signed [SW-1:0] sum;
        for (int i = 0; i < LANES; i++) begin
            if (dv_side.zero) begin
                mag = (i == 0) ? dv_side.ovl : '0;
            end else begin
                mag = dv_quo[i];
            end
            corr = $signed(SW'(mag));
            if (dv_side.dsign[i] && !dv_side.zero) begin
                corr = -corr;
            end
            if (!dv_side.push) begin
                corr = '0;
            end
            sum = SW'($signed(dv_side.pos[i])) + corr;
            if (sum > SAT_HI) begin
                sum = SAT_HI;
            end else if (sum < SAT_LO) begin
                sum = SAT_LO;
            end
            out_new_next[i] = sum[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_new_reg    <= out_new_next;
            m_pushed_reg <= dv_side.push;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'(m_new_reg);
    assign m_tuser  = m_pushed_reg;

    a_push_has_overlap : assert property (@(posedge aclk) disable iff (!aresetn)
        t4_valid_reg && t4_push_reg |-> t4_ovl_reg != '0)
        else $error("push without positive overlap");

    a_quo_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid && dv_side.push && !dv_side.zero |->
            dv_quo[0] <= dv_side.ovl && dv_quo[1] <= dv_side.ovl && dv_quo[2] <= dv_side.ovl)
        else $error("correction exceeds overlap");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(t1_valid_reg) && $stable(t4_valid_reg) && $stable(t5_valid_reg))
        else $error("pipeline moved during stall");

endmodule

// File: bench/tb_sphere_box_push_out_top.sv
// Testbench for the sphere box push-out pipeline: directed and random boxes, checked beat by beat.
`timescale 1ns / 1ps

module tb_sphere_box_push_out_top;

    localparam int CW        = 32;
    localparam int FB        = 12;
    localparam int RW        = sbpo_pkg::RADIUS_W;
    localparam int IN_W      = ((9*CW+RW+7)/8)*8;
    localparam int OUT_W     = ((3*CW+7)/8)*8;
    localparam int N_RANDOM  = 1730;
    localparam longint EPS_RAW = ((64'sd1 <<< FB) + 500) / 1000;
    localparam longint EPS_LEN = EPS_RAW > 0 ? EPS_RAW : 1;

    typedef struct packed {
        logic [RW-1:0] radius;
        logic signed [CW-1:0] pz, py, px;
        logic signed [CW-1:0] bxz, bxy, bxx;
        logic signed [CW-1:0] bnz, bny, bnx;
    } request_t;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        logic pushed;
    } center_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic m_tuser;

    center_t expected_centers[$];
    int  errors = 0;
    bit  quiet = 1'b0;

    sphere_box_push_out_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic longint clamp_axis(longint v, longint lo, longint hi);
        longint r;
        r = v < lo ? lo : v;
        return r > hi ? hi : r;
    endfunction

    function automatic longint sat_coord(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (CW-1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint unsigned mag, q;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic center_t push_out(request_t q);
        longint pos[3], d[3], corr[3], len, overlap, rad, lim;
        longint unsigned sum;
        bit far;
        center_t c;
        pos[0] = longint'(q.px); pos[1] = longint'(q.py); pos[2] = longint'(q.pz);
        d[0] = pos[0] - clamp_axis(pos[0], q.bnx, q.bxx);
        d[1] = pos[1] - clamp_axis(pos[1], q.bny, q.bxy);
        d[2] = pos[2] - clamp_axis(pos[2], q.bnz, q.bxz);
        rad = longint'(q.radius);
        lim = 64'sd1 <<< RW;
        far = 1'b0;
        corr = '{0, 0, 0};
        c.pushed = 1'b0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (d[i] >= lim || d[i] <= -lim) far = 1'b1;
            sum += d[i] * d[i];
        end
        if (!far) begin
            len = root_floor(sum);
            if (len == 0) begin
                overlap = rad - EPS_LEN;
                if (overlap > 0) begin
                    corr[0] = overlap;
                    c.pushed = 1'b1;
                end
            end else begin
                overlap = rad - len;
                if (overlap > 0) begin
                    for (int i = 0; i < 3; i++) corr[i] = div_round(d[i] * overlap, len);
                    c.pushed = 1'b1;
                end
            end
        end
        c.x = CW'(sat_coord(pos[0] + corr[0]));
        c.y = CW'(sat_coord(pos[1] + corr[1]));
        c.z = CW'(sat_coord(pos[2] + corr[2]));
        return c;
    endfunction

    task automatic send_request(request_t q);
        s_tdata  <= IN_W'(q);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_centers.insert(expected_centers.size(), push_out(q));
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= aresetn && (quiet || $urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        center_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_centers.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_centers.pop_front();
                if (m_tdata[CW-1:0] !== e.x) begin
                    $error("new_x expected %0d got %0d", e.x, $signed(m_tdata[CW-1:0]));
                    errors++;
                end
                if (m_tdata[2*CW-1:CW] !== e.y) begin
                    $error("new_y expected %0d got %0d", e.y, $signed(m_tdata[2*CW-1:CW]));
                    errors++;
                end
                if (m_tdata[3*CW-1:2*CW] !== e.z) begin
                    $error("new_z expected %0d got %0d", e.z,
                           $signed(m_tdata[3*CW-1:2*CW]));
                    errors++;
                end
                if (m_tuser !== e.pushed) begin
                    $error("pushed expected %0d got %0d", e.pushed, m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic request_t unit_box(longint px, longint py, longint pz, int rad);
        request_t q;
        q.bnx = 0; q.bny = 0; q.bnz = 0;
        q.bxx = 4096; q.bxy = 4096; q.bxz = 4096;
        q.px = CW'(px); q.py = CW'(py); q.pz = CW'(pz);
        q.radius = RW'(rad);
        return q;
    endfunction

    task automatic test_directed;
        request_t q;
        send_request(unit_box(2048, 2048, 2048, 2048));
        send_request(unit_box(2048, 2048, 2048, 0));
        send_request(unit_box(2048, 2048, 2048, 4));
        send_request(unit_box(2048, 2048, 2048, 5));
        send_request(unit_box(4096, 0, 4096, 100));
        send_request(unit_box(5000, 2048, 2048, 2048));
        send_request(unit_box(-1000, 6000, -2000, 8192));
        send_request(unit_box(5000, 2048, 2048, 904));
        send_request(unit_box(5000, 2048, 2048, 905));
        send_request(unit_box(4096 + (1 << 24), 0, 0, 24'hFFFFFF));
        send_request(unit_box(4096 + (1 << 24) - 1, 0, 0, 24'hFFFFFF));
        send_request(unit_box(-(1 << 24) + 1, -5, 0, 24'hFFFFFF));
        q = unit_box(0, 0, 0, 24'hFFFFFF);
        q.bnx = 32'sh7FFFFFF0; q.bxx = 32'sh7FFFFFFF; q.px = 32'sh7FFFFFFF;
        send_request(q);
        q = unit_box(0, 0, 0, 24'hFFFFFF);
        q.bnx = 32'sh80000000; q.bxx = 32'sh80000000; q.px = 32'sh80000000;
        q.bny = 32'sh80000000; q.bxy = 32'sh7FFFFFFF;
        send_request(q);
        q = unit_box(-100, 0, 0, 24'hFFFFFF);
        q.bnx = 32'sh80000000; q.bxx = 32'sh80000000 + 50;
        send_request(q);
        q = unit_box(3000, 2048, 2048, 2000);
        q.bnx = 4096; q.bxx = 2000;
        send_request(q);
        q = unit_box(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0);
        q.bnx = 32'sh7FFFFFFF; q.bny = 32'sh80000000; q.bxz = 32'sh80000000;
        send_request(q);
    endtask

    function automatic longint near_axis(longint lo, longint hi);
        int r;
        r = $urandom_range(9);
        if (r < 3) return lo - $urandom_range(20000);
        if (r < 6) return hi + $urandom_range(20000);
        if (r < 8) return lo + $urandom_range(4096);
        return $signed(32'($urandom));
    endfunction

    task automatic test_random;
        request_t q;
        longint b;
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 600 && n < 800);
            if ($urandom_range(9) < 8) begin
                b = $signed(32'($urandom)) >>> $urandom_range(0, 12);
                q.bnx = CW'(b);
                q.bxx = CW'(b + $urandom_range(0, 40000));
                q.bny = CW'(b - $urandom_range(0, 40000));
                q.bxy = CW'(b + $urandom_range(0, 40000));
                q.bnz = CW'(b - $urandom_range(0, 40000));
                q.bxz = CW'(b);
                if ($urandom_range(19) == 0) q.bxz = CW'(b - $urandom_range(1, 5000));
                q.px = CW'(sat_coord(near_axis(q.bnx, q.bxx)));
                q.py = CW'(sat_coord(near_axis(q.bny, q.bxy)));
                q.pz = CW'(sat_coord(near_axis(q.bnz, q.bxz)));
                q.radius = RW'($urandom_range(0, 1) ? $urandom_range(0, 40000) : $urandom);
            end else begin
                q = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
            end
            send_request(q);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random();
        wait (expected_centers.size() == 0);
        repeat (80) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
